[sv/tqle_pkg.sv]
package tqle_pkg;

	// Default build of the table.
	localparam int DEF_GRID_SIDE  = 32;
	localparam int DEF_VALUE_BITS = 32;

	// Fixed field widths.
	localparam int ACTIONS    = 4;
	localparam int ACT_W      = 2;
	localparam int COORD_W    = 5;
	localparam int REWARD_W   = 8;
	localparam int FRAC_W     = 16;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_RATE = 2'd2;

	// Register values after reset (about 0.1, 0.9 and 0.1 in Q0.16).
	localparam logic [FRAC_W-1:0] RST_LEARN_RATE   = 16'd6554;
	localparam logic [FRAC_W-1:0] RST_DISCOUNT     = 16'd58982;
	localparam logic [FRAC_W-1:0] RST_EXPLORE_RATE = 16'd6554;

	// Command codes of an input item.
	localparam logic CMD_CHOOSE = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MAX,
		ST_MUL1,
		ST_TGT,
		ST_DIFF,
		ST_MUL2,
		ST_FIN
	} tqle_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic rd_en;
		logic rd_next;
		logic pick;
		logic mul1;
		logic tgt;
		logic diff;
		logic mul2;
		logic finish;
	} tqle_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic is_update;
		logic out_free;
	} tqle_status_t;

endpackage

[sv/tqle_ctrl.sv]
module tqle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  tqle_pkg::tqle_status_t sts,
	output tqle_pkg::tqle_cmd_t    ctl
);

	tqle_pkg::tqle_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqle_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tqle_pkg::ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = tqle_pkg::ST_IDLE;
				end
			end
			tqle_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = tqle_pkg::ST_READ;
				end
			end
			tqle_pkg::ST_READ: begin
				// An update looks at the next cell first, a choose at the current one.
				ctl.rd_en   = 1'b1;
				ctl.rd_next = sts.is_update;
				state_d     = tqle_pkg::ST_MAX;
			end
			tqle_pkg::ST_MAX: begin
				ctl.pick = 1'b1;
				if (sts.is_update) begin
					ctl.rd_en = 1'b1;
					state_d   = tqle_pkg::ST_MUL1;
				end else begin
					state_d = tqle_pkg::ST_FIN;
				end
			end
			tqle_pkg::ST_MUL1: begin
				ctl.mul1 = 1'b1;
				state_d  = tqle_pkg::ST_TGT;
			end
			tqle_pkg::ST_TGT: begin
				ctl.tgt = 1'b1;
				state_d = tqle_pkg::ST_DIFF;
			end
			tqle_pkg::ST_DIFF: begin
				ctl.diff = 1'b1;
				state_d  = tqle_pkg::ST_MUL2;
			end
			tqle_pkg::ST_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = tqle_pkg::ST_FIN;
			end
			tqle_pkg::ST_FIN: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = tqle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tqle_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/tqle_dpath.sv]
module tqle_dpath #(
	parameter int GRID_SIDE  = tqle_pkg::DEF_GRID_SIDE,
	parameter int VALUE_BITS = tqle_pkg::DEF_VALUE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tqle_pkg::tqle_cmd_t                   ctl,
	output tqle_pkg::tqle_status_t                sts,
	input  logic                                  cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tqle_pkg::FRAC_W-1:0]           cfg_data,
	input  logic                                  cmd,
	input  logic [tqle_pkg::COORD_W-1:0]          state_x,
	input  logic [tqle_pkg::COORD_W-1:0]          state_y,
	input  logic [tqle_pkg::ACT_W-1:0]            taken_action,
	input  logic signed [tqle_pkg::REWARD_W-1:0]  reward,
	input  logic [tqle_pkg::COORD_W-1:0]          next_x,
	input  logic [tqle_pkg::COORD_W-1:0]          next_y,
	input  logic [tqle_pkg::FRAC_W-1:0]           random_fraction,
	input  logic [tqle_pkg::ACT_W-1:0]            random_action,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [tqle_pkg::ACT_W-1:0]            chosen_action,
	output logic                                  explored,
	output logic signed [tqle_pkg::OUT_W-1:0]     value_out
);

	localparam int VB    = VALUE_BITS;
	localparam int CW    = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int RW    = $clog2(CELLS);
	localparam int FW    = tqle_pkg::FRAC_W;
	localparam int SW    = ((VB > 24) ? VB : 24) + 1;
	localparam logic signed [SW-1:0] VMAX = SW'({1'b0, {(VB-1){1'b1}}});
	localparam logic signed [SW-1:0] VMIN = ~VMAX;

	// Configuration.
	logic [FW-1:0] learn_q, discount_q, explore_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q    <= tqle_pkg::RST_LEARN_RATE;
			discount_q <= tqle_pkg::RST_DISCOUNT;
			explore_q  <= tqle_pkg::RST_EXPLORE_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tqle_pkg::REG_LEARN_RATE:   learn_q    <= cfg_data;
				tqle_pkg::REG_DISCOUNT:     discount_q <= cfg_data;
				tqle_pkg::REG_EXPLORE_RATE: explore_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Coordinates past the grid edge clamp to the last row or column.
	function automatic logic [CW-1:0] clamp(input logic [tqle_pkg::COORD_W-1:0] c);
		if (int'(c) >= GRID_SIDE) begin
			return CW'(GRID_SIDE - 1);
		end
		return CW'(c);
	endfunction

	function automatic logic [RW-1:0] cell_addr(input logic [tqle_pkg::COORD_W-1:0] x,
			input logic [tqle_pkg::COORD_W-1:0] y);
		return RW'(RW'(clamp(x)) * RW'(GRID_SIDE) + RW'(clamp(y)));
	endfunction

	// Captured item.
	logic                        upd_q;
	logic [RW-1:0]               cur_addr_q, nxt_addr_q;
	logic [tqle_pkg::ACT_W-1:0]  act_in_q, rnd_act_q;
	logic signed [tqle_pkg::REWARD_W-1:0] rew_q;
	logic [FW-1:0]               rnd_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			upd_q      <= cmd;
			cur_addr_q <= cell_addr(state_x, state_y);
			nxt_addr_q <= cell_addr(next_x, next_y);
			act_in_q   <= taken_action;
			rew_q      <= reward;
			rnd_q      <= random_fraction;
			rnd_act_q  <= random_action;
		end
	end

	// Clearing sweep after reset.
	logic [RW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= clr_q + RW'(1);
		end
	end

	// Q table: one memory per action, all four read at the same cell.
	logic [RW-1:0]        rd_addr;
	logic signed [VB-1:0] rd_q [tqle_pkg::ACTIONS];
	logic signed [VB-1:0] new_val;

	assign rd_addr = ctl.rd_next ? nxt_addr_q : cur_addr_q;

	for (genvar a = 0; a < tqle_pkg::ACTIONS; a++) begin : g_lane
		logic [VB-1:0] mem [CELLS];

		always_ff @(posedge clk) begin
			if (ctl.clr_step) begin
				mem[clr_q] <= '0;
			end else if (ctl.finish && upd_q && act_in_q == tqle_pkg::ACT_W'(a)) begin
				mem[cur_addr_q] <= new_val;
			end
			if (ctl.rd_en) begin
				rd_q[a] <= mem[rd_addr];
			end
		end
	end

	// Greedy pick: a later action wins only if strictly greater.
	logic signed [VB-1:0]       best_c;
	logic [tqle_pkg::ACT_W-1:0] best_act_c;

	always_comb begin
		best_c     = rd_q[0];
		best_act_c = '0;
		for (int a = 1; a < tqle_pkg::ACTIONS; a++) begin
			if (rd_q[a] > best_c) begin
				best_c     = rd_q[a];
				best_act_c = tqle_pkg::ACT_W'(a);
			end
		end
	end

	logic signed [VB-1:0]       best_q, q_q, t_q;
	logic [tqle_pkg::ACT_W-1:0] best_act_q;
	logic signed [VB+FW:0]      prod1_q;
	logic signed [VB:0]         diff_q;
	logic signed [VB+FW+1:0]    prod2_q;
	logic signed [VB-1:0]       g_c, step_c;
	logic signed [SW-1:0]       sum_c, rew_ext_c;

	assign g_c       = VB'(prod1_q >>> FW);
	assign rew_ext_c = SW'(rew_q) <<< FW;
	assign sum_c     = SW'(g_c) + rew_ext_c;
	assign step_c    = VB'(prod2_q >>> FW);
	assign new_val   = q_q + step_c;

	always_ff @(posedge clk) begin
		if (ctl.pick) begin
			best_q     <= best_c;
			best_act_q <= best_act_c;
		end
		if (ctl.mul1) begin
			q_q     <= rd_q[act_in_q];
			prod1_q <= best_q * $signed({1'b0, discount_q});
		end
		if (ctl.tgt) begin
			if (sum_c > VMAX) begin
				t_q <= VB'(VMAX);
			end else if (sum_c < VMIN) begin
				t_q <= VB'(VMIN);
			end else begin
				t_q <= VB'(sum_c);
			end
		end
		if (ctl.diff) begin
			diff_q <= (VB+1)'(t_q) - (VB+1)'(q_q);
		end
		if (ctl.mul2) begin
			prod2_q <= diff_q * $signed({2'b00, learn_q});
		end
	end

	// Result register.
	logic                       out_valid_q, explored_q, explore_c;
	logic [tqle_pkg::ACT_W-1:0] chosen_q;
	logic signed [tqle_pkg::OUT_W-1:0] value_q;
	logic signed [VB-1:0]       res_c;
	logic signed [VB+tqle_pkg::OUT_W-1:0] res_ext_c;

	assign explore_c = rnd_q < explore_q;
	assign res_c     = upd_q ? new_val : best_q;
	assign res_ext_c = (VB+tqle_pkg::OUT_W)'(res_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			value_q <= res_ext_c[tqle_pkg::OUT_W-1:0];
			if (upd_q) begin
				chosen_q   <= '0;
				explored_q <= 1'b0;
			end else begin
				chosen_q   <= explore_c ? rnd_act_q : best_act_q;
				explored_q <= explore_c;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign chosen_action = chosen_q;
	assign explored      = explored_q;
	assign value_out     = value_q;

	assign sts.clr_last  = (clr_q == RW'(CELLS - 1));
	assign sts.is_update = (upd_q == tqle_pkg::CMD_UPDATE);
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

[sv/tabular_q_learning_engine.sv]
// Tabular Q-learning engine with epsilon-greedy action choice.
// Input channel (in_valid / in_stall) carries one command per beat. A choose
// beat returns the greedy action of the given cell, or the supplied random
// action when random_fraction is below explore_rate, together with the best
// value of the cell. An update beat applies Q += alpha*(target - Q) to one
// action of a cell and returns the new value.
// Output channel (out_valid / out_stall) carries exactly one result beat per
// input beat, in order. The result sits in an output register, so a new input
// beat is taken while an earlier result still waits for the receiver.
// A choose beat passes the READ and MAX states before the result register is
// loaded, an update beat READ, MAX, MUL1, TGT, DIFF and MUL2, set by the
// single read port of the table and the two dependent multiplies that run one
// after the other in the datapath. One item is worked on at a time; the next
// beat is taken the cycle after the result is loaded. If the receiver stalls
// while a result is still held, a finished item waits in the datapath until
// the output register frees up. After reset the table is swept to zero, one
// cell a cycle, with in_stall high. Configuration writes are taken at any
// time but should only be issued while the block is idle.
module tabular_q_learning_engine #(
	parameter int GRID_SIDE  = tqle_pkg::DEF_GRID_SIDE,
	parameter int VALUE_BITS = tqle_pkg::DEF_VALUE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tqle_pkg::FRAC_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [tqle_pkg::COORD_W-1:0]          state_x,
	input  logic [tqle_pkg::COORD_W-1:0]          state_y,
	input  logic [tqle_pkg::ACT_W-1:0]            taken_action,
	input  logic signed [tqle_pkg::REWARD_W-1:0]  reward,
	input  logic [tqle_pkg::COORD_W-1:0]          next_x,
	input  logic [tqle_pkg::COORD_W-1:0]          next_y,
	input  logic [tqle_pkg::FRAC_W-1:0]           random_fraction,
	input  logic [tqle_pkg::ACT_W-1:0]            random_action,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [tqle_pkg::ACT_W-1:0]            chosen_action,
	output logic                                  explored,
	output logic signed [tqle_pkg::OUT_W-1:0]     value_out
);

	// The controller sequences the table reads and arithmetic steps; the
	// datapath holds the table, the configuration and the result register.
	tqle_pkg::tqle_cmd_t    ctl;
	tqle_pkg::tqle_status_t sts;

	tqle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	tqle_dpath #(
		.GRID_SIDE  (GRID_SIDE),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.state_x         (state_x),
		.state_y         (state_y),
		.taken_action    (taken_action),
		.reward          (reward),
		.next_x          (next_x),
		.next_y          (next_y),
		.random_fraction (random_fraction),
		.random_action   (random_action),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chosen_action   (chosen_action),
		.explored        (explored),
		.value_out       (value_out)
	);

endmodule

[sv/tqle_checker.sv]
module tqle_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [tqle_pkg::ACT_W-1:0]        chosen_action,
	input logic                              explored,
	input logic signed [tqle_pkg::OUT_W-1:0] value_out
);

	logic       in_beat, out_beat;
	logic [1:0] pend_q;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// Items accepted whose result has not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	// The engine works on one item at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input taken again right after a beat");

	// At most one finished result waits while another item is taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> (pend_q != 2'd2 && pend_q != 2'd3))
		else $error("input taken with two items outstanding");

	// No result without an item behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result shown with no item outstanding");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out)
			&& $stable(chosen_action) && $stable(explored))
		else $error("stalled result changed");

endmodule

bind tabular_q_learning_engine tqle_checker u_tqle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.chosen_action (chosen_action),
	.explored      (explored),
	.value_out     (value_out)
);

[bench/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the tabular Q-learning engine.
//
// Choose beats and update beats go in on the input channel. Every beat that
// the block takes is run at once through a bit-exact Q-table predictor kept
// here. The predictor mirrors the block's table and its three registers and
// queues the one result beat that the block owes for it. A monitor takes the
// result beats off the output channel and compares each one, field by field,
// with the oldest result still owed.
//
// Both channels idle at random. The run also covers these cases:
// - one long receiver hold-off that backs the block up into its input;
// - one stretch with no idling at all;
// - a climb that saturates a table value at the top of the signed range;
// - the register extremes.
// Registers are only written while the block is drained.
module tb;

	localparam int TABLE_DEPTH =
		tqle_pkg::DEF_GRID_SIDE * tqle_pkg::DEF_GRID_SIDE * tqle_pkg::ACTIONS;
	// The register port has one index that maps to no register.
	localparam logic [tqle_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint VALUE_MAX = 64'sd2147483647;
	localparam longint VALUE_MIN = -64'sd2147483648;
	// This outlasts any update, so it settles any work in flight.
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	// The clearing sweep after reset plus the long hold-off
	// are the longest quiet stretches of a correct run.
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic cmd;
		logic [tqle_pkg::COORD_W-1:0] sx;
		logic [tqle_pkg::COORD_W-1:0] sy;
		logic [tqle_pkg::ACT_W-1:0] act;
		logic signed [tqle_pkg::REWARD_W-1:0] reward;
		logic [tqle_pkg::COORD_W-1:0] nx;
		logic [tqle_pkg::COORD_W-1:0] ny;
		logic [tqle_pkg::FRAC_W-1:0] frac;
		logic [tqle_pkg::ACT_W-1:0] ract;
	} q_beat_t;

	typedef struct {
		logic [tqle_pkg::ACT_W-1:0] action;
		logic explored;
		logic signed [tqle_pkg::OUT_W-1:0] value;
	} q_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tqle_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tqle_pkg::FRAC_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = tqle_pkg::CMD_CHOOSE;
	logic [tqle_pkg::COORD_W-1:0] state_x = '0;
	logic [tqle_pkg::COORD_W-1:0] state_y = '0;
	logic [tqle_pkg::ACT_W-1:0] taken_action = '0;
	logic signed [tqle_pkg::REWARD_W-1:0] reward = '0;
	logic [tqle_pkg::COORD_W-1:0] next_x = '0;
	logic [tqle_pkg::COORD_W-1:0] next_y = '0;
	logic [tqle_pkg::FRAC_W-1:0] random_fraction = '0;
	logic [tqle_pkg::ACT_W-1:0] random_action = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [tqle_pkg::ACT_W-1:0] chosen_action;
	logic explored;
	logic signed [tqle_pkg::OUT_W-1:0] value_out;

	// Predictor state: the mirrored Q table and the register copies.
	logic signed [tqle_pkg::OUT_W-1:0] q_values [TABLE_DEPTH];
	logic [tqle_pkg::FRAC_W-1:0] alpha_q;
	logic [tqle_pkg::FRAC_W-1:0] gamma_q;
	logic [tqle_pkg::FRAC_W-1:0] epsilon_q;

	// Beats waiting for the driver, the beat on the wires, and owed results.
	q_beat_t beats_to_send[$];
	q_beat_t beat_on_bus;
	q_result_t results_owed[$];
	q_result_t want_result;

	logic beat_taken = 1'b0;
	logic steady = 1'b0;
	int beats_queued = 0;
	int beats_taken = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int idle_cycles = 0;
	int failures = 0;
	int n_choose = 0;
	int n_update = 0;
	int n_explore = 0;
	int n_clipped = 0;
	int reg_writes = 0;

	tabular_q_learning_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.state_x(state_x),
		.state_y(state_y),
		.taken_action(taken_action),
		.reward(reward),
		.next_x(next_x),
		.next_y(next_y),
		.random_fraction(random_fraction),
		.random_action(random_action),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_action(chosen_action),
		.explored(explored),
		.value_out(value_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Q-table predictor
	// ------------------------------------------------------------------

	// First table entry of a grid square. A 5-bit coordinate always lies
	// inside the 32-wide grid, so no clamping is needed here.
	function automatic int unsigned slot_base(logic [tqle_pkg::COORD_W-1:0] x,
			logic [tqle_pkg::COORD_W-1:0] y);
		return (int'(x) * tqle_pkg::DEF_GRID_SIDE + int'(y)) * tqle_pkg::ACTIONS;
	endfunction

	// Greedy action of a square. Only a strictly larger value takes over,
	// so the lowest action index wins a tie.
	function automatic logic [tqle_pkg::ACT_W-1:0] greedy_pick(int unsigned base,
			output longint best);
		logic [tqle_pkg::ACT_W-1:0] pick;
		int a;
		pick = '0;
		best = q_values[base];
		for (a = 1; a < tqle_pkg::ACTIONS; a++) begin
			if (q_values[base + a] > best) begin
				best = q_values[base + a];
				pick = tqle_pkg::ACT_W'(a);
			end
		end
		return pick;
	endfunction

	// Works out the result of one beat and applies its table write.
	function automatic q_result_t apply_beat(q_beat_t b);
		q_result_t r;
		int unsigned slot;
		longint best;
		longint target;
		longint q_old;
		longint fresh;
		logic [tqle_pkg::ACT_W-1:0] pick;
		r.action = '0;
		r.explored = 1'b0;
		if (b.cmd == tqle_pkg::CMD_CHOOSE) begin
			n_choose++;
			pick = greedy_pick(slot_base(b.sx, b.sy), best);
			// Explore when the draw falls below epsilon. The reported value
			// is the best value of the square either way.
			if (b.frac < epsilon_q) begin
				r.action = b.ract;
				r.explored = 1'b1;
				n_explore++;
			end else begin
				r.action = pick;
			end
			r.value = best[tqle_pkg::OUT_W-1:0];
		end else begin
			n_update++;
			slot = slot_base(b.sx, b.sy) + b.act;
			void'(greedy_pick(slot_base(b.nx, b.ny), best));
			// The discounted max is floored (arithmetic shift). The target is
			// then clamped to the signed 32-bit range.
			target = longint'(b.reward) * 65536 + ((best * longint'(gamma_q)) >>> 16);
			if (target > VALUE_MAX || target < VALUE_MIN)
				n_clipped++;
			if (target > VALUE_MAX)
				target = VALUE_MAX;
			if (target < VALUE_MIN)
				target = VALUE_MIN;
			// The blend lands between the old value and the target, so it
			// stays in range without a second clamp.
			q_old = q_values[slot];
			fresh = q_old + (((target - q_old) * longint'(alpha_q)) >>> 16);
			q_values[slot] = fresh[tqle_pkg::OUT_W-1:0];
			r.value = fresh[tqle_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// Fields that a command ignores still carry random bits.
	function automatic q_beat_t random_beat();
		q_beat_t b;
		b.cmd = 1'($urandom);
		b.sx = tqle_pkg::COORD_W'($urandom);
		b.sy = tqle_pkg::COORD_W'($urandom);
		b.act = tqle_pkg::ACT_W'($urandom);
		b.reward = tqle_pkg::REWARD_W'($urandom);
		b.nx = tqle_pkg::COORD_W'($urandom);
		b.ny = tqle_pkg::COORD_W'($urandom);
		b.frac = tqle_pkg::FRAC_W'($urandom);
		b.ract = tqle_pkg::ACT_W'($urandom);
		return b;
	endfunction

	function automatic q_beat_t choose_beat(int x, int y,
			logic [tqle_pkg::FRAC_W-1:0] frac, logic [tqle_pkg::ACT_W-1:0] ract);
		q_beat_t b;
		b = random_beat();
		b.cmd = tqle_pkg::CMD_CHOOSE;
		b.sx = tqle_pkg::COORD_W'(x);
		b.sy = tqle_pkg::COORD_W'(y);
		b.frac = frac;
		b.ract = ract;
		return b;
	endfunction

	function automatic q_beat_t update_beat(int x, int y,
			logic [tqle_pkg::ACT_W-1:0] act, int rew, int nx, int ny);
		q_beat_t b;
		b = random_beat();
		b.cmd = tqle_pkg::CMD_UPDATE;
		b.sx = tqle_pkg::COORD_W'(x);
		b.sy = tqle_pkg::COORD_W'(y);
		b.act = act;
		b.reward = tqle_pkg::REWARD_W'(rew);
		b.nx = tqle_pkg::COORD_W'(nx);
		b.ny = tqle_pkg::COORD_W'(ny);
		return b;
	endfunction

	task automatic queue_beat(q_beat_t b);
		beats_to_send = {beats_to_send, b};
		beats_queued++;
	endtask

	// Waits until every queued beat has been taken and every owed result has
	// come back, then lets the block settle before anything else happens.
	task automatic drain();
		do
			@(negedge clk);
		while (beats_taken != beats_queued || results_owed.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [tqle_pkg::CFG_IDX_W-1:0] idx,
			logic [tqle_pkg::FRAC_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		// A write to the spare index changes nothing.
		case (idx)
			tqle_pkg::REG_LEARN_RATE: alpha_q = data;
			tqle_pkg::REG_DISCOUNT: gamma_q = data;
			tqle_pkg::REG_EXPLORE_RATE: epsilon_q = data;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Hand-picked beats for the reset settings. The table starts at zero, so
	// the first choose is an all-way tie. After that the beats cover the
	// exploring boundary on both sides, the reward extremes, and the grid
	// corners.
	task automatic run_directed();
		queue_beat(choose_beat(0, 0, 16'hFFFF, 2'd3));
		queue_beat(choose_beat(31, 31, 16'h0000, 2'd3));
		queue_beat(choose_beat(31, 0, tqle_pkg::RST_EXPLORE_RATE - 16'd1, 2'd2));
		queue_beat(choose_beat(0, 31, tqle_pkg::RST_EXPLORE_RATE, 2'd1));
		queue_beat(update_beat(0, 0, 2'd0, 127, 31, 31));
		queue_beat(update_beat(0, 0, 2'd3, -128, 0, 0));
		queue_beat(update_beat(0, 0, 2'd2, 127, 0, 0));
		queue_beat(choose_beat(0, 0, 16'hFFFF, 2'd0));
		// Actions 1 and 3 end up equal here, so the greedy pick must be 1.
		queue_beat(update_beat(5, 5, 2'd1, 1, 10, 10));
		queue_beat(update_beat(5, 5, 2'd3, 1, 10, 10));
		queue_beat(choose_beat(5, 5, 16'hFFFF, 2'd0));
		queue_beat(update_beat(31, 31, 2'd3, 127, 0, 0));
		queue_beat(update_beat(31, 31, 2'd0, -1, 31, 31));
		queue_beat(update_beat(31, 31, 2'd1, 0, 31, 31));
		queue_beat(choose_beat(31, 31, 16'h8000, 2'd3));
		queue_beat(update_beat(0, 0, 2'd3, -128, 0, 0));
		queue_beat(choose_beat(0, 0, tqle_pkg::RST_EXPLORE_RATE - 16'd1, 2'd0));
		queue_beat(choose_beat(16, 15, 16'h5555, 2'd1));
		queue_beat(update_beat(21, 10, 2'd2, 85, 10, 21));
		queue_beat(choose_beat(10, 21, 16'hAAAA, 2'd2));
	endtask

	// Walks through a square patch of the grid the way an agent would. Each
	// step is a choose at the current square, then an update for a move to a
	// neighbor. Episodes restart now and then. About one beat in twelve is
	// an unrelated random beat anywhere on the grid.
	task automatic run_episodes(int count, int span);
		int x;
		int y;
		int nx;
		int ny;
		int dir;
		int made;
		int rew;
		logic [tqle_pkg::FRAC_W-1:0] frac;
		x = int'($urandom_range(0, span - 1));
		y = int'($urandom_range(0, span - 1));
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_beat(random_beat());
				made++;
			end else begin
				// Draws right at epsilon probe the exploring boundary.
				if ($urandom_range(0, 9) == 0)
					frac = epsilon_q - tqle_pkg::FRAC_W'($urandom_range(0, 1));
				else
					frac = tqle_pkg::FRAC_W'($urandom);
				queue_beat(choose_beat(x, y, frac, tqle_pkg::ACT_W'($urandom)));
				dir = int'($urandom_range(0, 3));
				nx = x;
				ny = y;
				case (dir)
					0: nx = (x > 0) ? x - 1 : x;
					1: nx = (x < span - 1) ? x + 1 : x;
					2: ny = (y > 0) ? y - 1 : y;
					default: ny = (y < span - 1) ? y + 1 : y;
				endcase
				case ($urandom_range(0, 9))
					0: rew = 127;
					1: rew = -128;
					default: rew = int'($urandom_range(0, 255)) - 128;
				endcase
				queue_beat(update_beat(x, y, tqle_pkg::ACT_W'(dir), rew, nx, ny));
				made += 2;
				x = nx;
				y = ny;
				if ($urandom_range(0, 19) == 0) begin
					x = int'($urandom_range(0, span - 1));
					y = int'($urandom_range(0, span - 1));
				end
			end
		end
	endtask

	// One square loops onto itself with the top reward. With alpha and gamma
	// near one, each update adds about 127.0 to the value, so a few hundred
	// updates are enough to reach the top of the range and clamp there.
	task automatic run_climb(int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 85)
				queue_beat(update_beat(9, 9, 2'd1, 127, 9, 9));
			else
				queue_beat(choose_beat(9, 9, tqle_pkg::FRAC_W'($urandom),
					tqle_pkg::ACT_W'($urandom)));
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Beats are counted and predicted at the edge where the block takes them.
	// The prediction runs in the order the beats are taken, which is the
	// order the block works on them.
	always @(posedge clk) begin
		beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			results_owed = {results_owed, apply_beat(beat_on_bus)};
			beats_taken++;
		end
	end

	// Driver. A beat on offer stays put until it has been taken. After each
	// taken beat there may be a random gap before the next one.
	always @(negedge clk) begin
		if (in_valid && !beat_taken) begin
			// Still waiting for the block to take the beat on the wires.
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (beats_to_send.size() != 0) begin
			beat_on_bus = beats_to_send.pop_front();
			in_valid <= 1'b1;
			cmd <= beat_on_bus.cmd;
			state_x <= beat_on_bus.sx;
			state_y <= beat_on_bus.sy;
			taken_action <= beat_on_bus.act;
			reward <= beat_on_bus.reward;
			next_x <= beat_on_bus.nx;
			next_y <= beat_on_bus.ny;
			random_fraction <= beat_on_bus.frac;
			random_action <= beat_on_bus.ract;
			send_gap = steady ? 0 : gap_length();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver stalls. A hold-off request from the main sequence takes
	// priority. It keeps the output stalled for a long, counted stretch while
	// the sender keeps offering beats, so the output register and the
	// datapath fill up and the block has to stall its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left = gap_length();
		end
	end

	// Monitor. Every result beat must match the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_owed.size() == 0) begin
				$error("result beat with no result owed: value_out %0d", value_out);
				failures++;
			end else begin
				want_result = results_owed.pop_front();
				if (chosen_action !== want_result.action) begin
					$error("chosen_action: expected %0d, got %0d",
						want_result.action, chosen_action);
					failures++;
				end
				if (explored !== want_result.explored) begin
					$error("explored: expected %0d, got %0d", want_result.explored, explored);
					failures++;
				end
				if (value_out !== want_result.value) begin
					$error("value_out: expected %0d, got %0d", want_result.value, value_out);
					failures++;
				end
			end
		end
	end

	// Watchdog. It ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int i;
		for (i = 0; i < TABLE_DEPTH; i++)
			q_values[i] = '0;
		alpha_q = tqle_pkg::RST_LEARN_RATE;
		gamma_q = tqle_pkg::RST_DISCOUNT;
		epsilon_q = tqle_pkg::RST_EXPLORE_RATE;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings. The directed beats wait out the clearing sweep.
		run_directed();
		drain();

		// Same settings with random walks. The long hold-off starts at once,
		// so the walks pile up against a blocked output.
		holds_asked++;
		run_episodes(280, 4);
		drain();

		// Alpha and gamma at their maximum and no exploring: the climb to
		// the clamp. The spare index is written too and must be ignored.
		write_reg(tqle_pkg::REG_LEARN_RATE, 16'hFFFF);
		write_reg(tqle_pkg::REG_DISCOUNT, 16'hFFFF);
		write_reg(tqle_pkg::REG_EXPLORE_RATE, 16'h0000);
		write_reg(REG_SPARE, tqle_pkg::FRAC_W'($urandom));
		run_climb(360);
		drain();

		// The opposite extremes. The table must stay frozen while nearly
		// every choose explores.
		write_reg(tqle_pkg::REG_LEARN_RATE, 16'h0000);
		write_reg(tqle_pkg::REG_DISCOUNT, 16'h0000);
		write_reg(tqle_pkg::REG_EXPLORE_RATE, 16'hFFFF);
		run_episodes(200, 32);
		drain();

		// Random settings.
		write_reg(tqle_pkg::REG_LEARN_RATE, tqle_pkg::FRAC_W'($urandom));
		write_reg(tqle_pkg::REG_DISCOUNT, tqle_pkg::FRAC_W'($urandom));
		write_reg(tqle_pkg::REG_EXPLORE_RATE, tqle_pkg::FRAC_W'($urandom));
		run_episodes(280, 8);
		drain();

		// Random settings again, with both sides going flat out.
		write_reg(tqle_pkg::REG_LEARN_RATE, tqle_pkg::FRAC_W'($urandom));
		write_reg(tqle_pkg::REG_DISCOUNT, tqle_pkg::FRAC_W'($urandom));
		write_reg(tqle_pkg::REG_EXPLORE_RATE, tqle_pkg::FRAC_W'($urandom));
		steady = 1'b1;
		run_episodes(280, 4);
		drain();

		$display("Checked %0d choose beats (%0d explored) and %0d update beats.",
			n_choose, n_explore, n_update);
		$display("%0d updates clamped their target; %0d register writes over five settings.",
			n_clipped, reg_writes);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
